### rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and codes of the complex arithmetic unit
// Opcodes, status codes, divider width and the side record that travels
// with each request down the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_EQ  = 3'd5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // quotient bits kept by the divider: enough to tell 2^31 from larger
    localparam int QBITS = 33;

    // result of the non-divide ops plus divide flags
    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        ovf;
        logic        is_div;
        logic        dz;
    } t_side;

endpackage

### rtl/complex_arith_unit_top.sv
// Pipeline: a request accepted at one edge passes 38 register stages (3 front,
// 34 divider, 1 output) before it is presented on o_valid, for every opcode.
// Throughput: one request per clock; busy is always low, and the receiver
// cannot stall, so results simply stream out in request order.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
// ----------------------------------------------------------------------------
// complex_arith_unit_top: pipelined Q-format complex ALU
// Add, subtract, negate, multiply, divide and equality on signed complex
// operands with saturation and overflow / divide-by-zero status.
// ----------------------------------------------------------------------------
module complex_arith_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_valid,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic               o_is_equal,
    output logic [1:0]         o_status
);
    import cau_pkg::*;

    // Every stage advances each cycle, so a request is never refused.
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // Front: products, wide sums, multiply results, divide magnitudes.
    logic        f_valid;
    t_side       f_side;
    logic [63:0] f_mag_re, f_mag_im, f_den;
    logic        f_neg_re, f_neg_im;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_opcode (i_opcode),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_valid  (f_valid),
        .o_side   (f_side),
        .o_mag_re (f_mag_re),
        .o_neg_re (f_neg_re),
        .o_mag_im (f_mag_im),
        .o_neg_im (f_neg_im),
        .o_den    (f_den)
    );

    // Divider: all opcodes pass through it so ordering and latency stay fixed;
    // the side record carries the non-divide result alongside.
    logic             d_valid;
    t_side            d_side;
    logic [QBITS-1:0] d_q_re, d_q_im;
    logic             d_neg_re, d_neg_im, d_ovf_re, d_ovf_im;

    cau_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .i_side   (f_side),
        .i_mag_re (f_mag_re),
        .i_neg_re (f_neg_re),
        .i_mag_im (f_mag_im),
        .i_neg_im (f_neg_im),
        .i_den    (f_den),
        .o_valid  (d_valid),
        .o_side   (d_side),
        .o_q_re   (d_q_re),
        .o_neg_re (d_neg_re),
        .o_ovf_re (d_ovf_re),
        .o_q_im   (d_q_im),
        .o_neg_im (d_neg_im),
        .o_ovf_im (d_ovf_im)
    );

    // Output stage: quotient sign/saturation, result select, status.
    logic [31:0] w_re, w_im;

    cau_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (d_valid),
        .i_side     (d_side),
        .i_q_re     (d_q_re),
        .i_neg_re   (d_neg_re),
        .i_ovf_re   (d_ovf_re),
        .i_q_im     (d_q_im),
        .i_neg_im   (d_neg_im),
        .i_ovf_im   (d_ovf_im),
        .o_valid    (o_valid),
        .o_res_re   (w_re),
        .o_res_im   (w_im),
        .o_is_equal (o_is_equal),
        .o_status   (o_status)
    );

    assign o_res_re = $signed(w_re);
    assign o_res_im = $signed(w_im);

endmodule

### rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: multiply, sum and prepare stages
// Stage 1 forms six 32x32 products and the add/sub/negate/equal results,
// stage 2 the wide sums and the divisor norm, stage 3 the multiply
// saturation and the divide numerator magnitudes.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2:0]          i_opcode,
    input  logic signed [31:0]  i_a_re,
    input  logic signed [31:0]  i_a_im,
    input  logic signed [31:0]  i_b_re,
    input  logic signed [31:0]  i_b_im,
    output logic                o_valid,
    output cau_pkg::t_side      o_side,
    output logic [63:0]         o_mag_re,
    output logic                o_neg_re,
    output logic [63:0]         o_mag_im,
    output logic                o_neg_im,
    output logic [63:0]         o_den
);
    import cau_pkg::*;

    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic ovf;
        ovf = v[32] != v[31];
        if (ovf) begin
            return {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] sat65(input logic signed [64:0] v);
        logic ovf;
        ovf = !((&v[64:31]) || (~|v[64:31]));
        if (ovf) begin
            return {1'b1, v[64] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return {1'b0, v[31:0]};
    endfunction

    // ---- stage 1 ----
    logic signed [32:0] n_sre, n_sim;
    logic [32:0]        n_sat_re, n_sat_im;

    always_comb begin
        unique case (i_opcode)
            OP_ADD: begin
                n_sre = 33'(i_a_re) + 33'(i_b_re);
                n_sim = 33'(i_a_im) + 33'(i_b_im);
            end
            OP_SUB: begin
                n_sre = 33'(i_a_re) - 33'(i_b_re);
                n_sim = 33'(i_a_im) - 33'(i_b_im);
            end
            OP_NEG: begin
                n_sre = 33'sd0 - 33'(i_a_re);
                n_sim = 33'sd0 - 33'(i_a_im);
            end
            default: begin
                n_sre = '0;
                n_sim = '0;
            end
        endcase
        n_sat_re = sat33(n_sre);
        n_sat_im = sat33(n_sim);
    end

    logic               r1_valid;
    logic [2:0]         r1_op;
    logic [31:0]        r1_sre, r1_sim;
    logic               r1_sovf, r1_eq;
    logic signed [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_bb, r1_p_cc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_op   <= i_opcode;
        r1_sre  <= n_sat_re[31:0];
        r1_sim  <= n_sat_im[31:0];
        r1_sovf <= n_sat_re[32] | n_sat_im[32];
        r1_eq   <= (i_opcode == OP_EQ) && (i_a_re == i_b_re) && (i_a_im == i_b_im);
        r1_p_rr <= i_a_re * i_b_re;
        r1_p_ii <= i_a_im * i_b_im;
        r1_p_ri <= i_a_re * i_b_im;
        r1_p_ir <= i_a_im * i_b_re;
        r1_p_bb <= i_b_re * i_b_re;
        r1_p_cc <= i_b_im * i_b_im;
    end

    // ---- stage 2 ----
    logic               r2_valid;
    logic [2:0]         r2_op;
    logic [31:0]        r2_sre, r2_sim;
    logic               r2_sovf, r2_eq;
    logic signed [64:0] r2_m_re, r2_m_im, r2_d_re, r2_d_im;
    logic [63:0]        r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_op   <= r1_op;
        r2_sre  <= r1_sre;
        r2_sim  <= r1_sim;
        r2_sovf <= r1_sovf;
        r2_eq   <= r1_eq;
        r2_m_re <= 65'(r1_p_rr) - 65'(r1_p_ii);
        r2_m_im <= 65'(r1_p_ri) + 65'(r1_p_ir);
        r2_d_re <= 65'(r1_p_rr) + 65'(r1_p_ii);
        r2_d_im <= 65'(r1_p_ir) - 65'(r1_p_ri);
        r2_den  <= $unsigned(r1_p_bb) + $unsigned(r1_p_cc);
    end

    // ---- stage 3 ----
    logic signed [64:0] n_sh_re, n_sh_im, n_ng_re, n_ng_im;
    logic [32:0]        n_mul_re, n_mul_im;
    t_side              n_side;

    always_comb begin
        n_sh_re  = r2_m_re >>> FRAC_BITS;
        n_sh_im  = r2_m_im >>> FRAC_BITS;
        n_mul_re = sat65(n_sh_re);
        n_mul_im = sat65(n_sh_im);
        n_ng_re  = 65'sd0 - r2_d_re;
        n_ng_im  = 65'sd0 - r2_d_im;
        n_side   = '0;
        unique case (r2_op)
            OP_ADD, OP_SUB, OP_NEG: begin
                n_side.re  = r2_sre;
                n_side.im  = r2_sim;
                n_side.ovf = r2_sovf;
            end
            OP_MUL: begin
                n_side.re  = n_mul_re[31:0];
                n_side.im  = n_mul_im[31:0];
                n_side.ovf = n_mul_re[32] | n_mul_im[32];
            end
            OP_DIV: begin
                n_side.is_div = 1'b1;
                n_side.dz     = r2_den == 64'd0;
            end
            OP_EQ: begin
                n_side.eq = r2_eq;
            end
            default: begin
                n_side = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r2_valid;
        end
        o_side   <= n_side;
        o_neg_re <= r2_d_re[64];
        o_neg_im <= r2_d_im[64];
        o_mag_re <= r2_d_re[64] ? n_ng_re[63:0] : r2_d_re[63:0];
        o_mag_im <= r2_d_im[64] ? n_ng_im[63:0] : r2_d_im[63:0];
        o_den    <= r2_den;
    end

endmodule

### rtl/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider: pipelined restoring divider for both result parts
// One range check stage, then one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module cau_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  cau_pkg::t_side         i_side,
    input  logic [63:0]            i_mag_re,
    input  logic                   i_neg_re,
    input  logic [63:0]            i_mag_im,
    input  logic                   i_neg_im,
    input  logic [63:0]            i_den,
    output logic                   o_valid,
    output cau_pkg::t_side         o_side,
    output logic [cau_pkg::QBITS-1:0] o_q_re,
    output logic                   o_neg_re,
    output logic                   o_ovf_re,
    output logic [cau_pkg::QBITS-1:0] o_q_im,
    output logic                   o_neg_im,
    output logic                   o_ovf_im
);
    import cau_pkg::*;

    localparam int DW = 64 + FRAC_BITS;

    logic [DW-1:0] n_d_re, n_d_im;
    logic [63:0]   n_hi_re, n_hi_im;

    always_comb begin
        n_d_re  = DW'(i_mag_re) << FRAC_BITS;
        n_d_im  = DW'(i_mag_im) << FRAC_BITS;
        n_hi_re = 64'(n_d_re[DW-1:QBITS]);
        n_hi_im = 64'(n_d_im[DW-1:QBITS]);
    end

    logic             r_valid [0:QBITS];
    t_side            r_side  [0:QBITS];
    logic [63:0]      r_den   [0:QBITS];
    logic [63:0]      r_rem_re [0:QBITS];
    logic [63:0]      r_rem_im [0:QBITS];
    logic [QBITS-1:0] r_low_re [0:QBITS];
    logic [QBITS-1:0] r_low_im [0:QBITS];
    logic [QBITS-1:0] r_q_re   [0:QBITS];
    logic [QBITS-1:0] r_q_im   [0:QBITS];
    logic             r_neg_re [0:QBITS];
    logic             r_neg_im [0:QBITS];
    logic             r_ovf_re [0:QBITS];
    logic             r_ovf_im [0:QBITS];

    // range check: quotient of 2^33 or more already saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
        r_side[0]   <= i_side;
        r_den[0]    <= i_den;
        r_rem_re[0] <= n_hi_re;
        r_rem_im[0] <= n_hi_im;
        r_low_re[0] <= n_d_re[QBITS-1:0];
        r_low_im[0] <= n_d_im[QBITS-1:0];
        r_q_re[0]   <= '0;
        r_q_im[0]   <= '0;
        r_neg_re[0] <= i_neg_re;
        r_neg_im[0] <= i_neg_im;
        r_ovf_re[0] <= n_hi_re >= i_den;
        r_ovf_im[0] <= n_hi_im >= i_den;
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_step
        logic [64:0] n_t_re, n_t_im, n_df_re, n_df_im;

        always_comb begin
            n_t_re  = {1'b0, r_rem_re[k-1][62:0], r_low_re[k-1][QBITS-1]};
            n_t_im  = {1'b0, r_rem_im[k-1][62:0], r_low_im[k-1][QBITS-1]};
            n_df_re = n_t_re - {1'b0, r_den[k-1]};
            n_df_im = n_t_im - {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= r_valid[k-1];
            end
            r_side[k]   <= r_side[k-1];
            r_den[k]    <= r_den[k-1];
            r_rem_re[k] <= n_df_re[64] ? n_t_re[63:0] : n_df_re[63:0];
            r_rem_im[k] <= n_df_im[64] ? n_t_im[63:0] : n_df_im[63:0];
            r_low_re[k] <= {r_low_re[k-1][QBITS-2:0], 1'b0};
            r_low_im[k] <= {r_low_im[k-1][QBITS-2:0], 1'b0};
            r_q_re[k]   <= {r_q_re[k-1][QBITS-2:0], ~n_df_re[64]};
            r_q_im[k]   <= {r_q_im[k-1][QBITS-2:0], ~n_df_im[64]};
            r_neg_re[k] <= r_neg_re[k-1];
            r_neg_im[k] <= r_neg_im[k-1];
            r_ovf_re[k] <= r_ovf_re[k-1];
            r_ovf_im[k] <= r_ovf_im[k-1];
        end
    end

    assign o_valid  = r_valid[QBITS];
    assign o_side   = r_side[QBITS];
    assign o_q_re   = r_q_re[QBITS];
    assign o_q_im   = r_q_im[QBITS];
    assign o_neg_re = r_neg_re[QBITS];
    assign o_neg_im = r_neg_im[QBITS];
    assign o_ovf_re = r_ovf_re[QBITS];
    assign o_ovf_im = r_ovf_im[QBITS];

endmodule

### rtl/cau_out.sv
// ----------------------------------------------------------------------------
// cau_out: result stage
// Signs and saturates the quotients, picks the result and status, and
// registers the output strobe.
// ----------------------------------------------------------------------------
module cau_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  cau_pkg::t_side            i_side,
    input  logic [cau_pkg::QBITS-1:0] i_q_re,
    input  logic                      i_neg_re,
    input  logic                      i_ovf_re,
    input  logic [cau_pkg::QBITS-1:0] i_q_im,
    input  logic                      i_neg_im,
    input  logic                      i_ovf_im,
    output logic                      o_valid,
    output logic [31:0]               o_res_re,
    output logic [31:0]               o_res_im,
    output logic                      o_is_equal,
    output logic [1:0]                o_status
);
    import cau_pkg::*;

    localparam logic [QBITS-1:0] LIM_POS = QBITS'(32'h7FFF_FFFF);
    localparam logic [QBITS-1:0] LIM_NEG = QBITS'(33'h0_8000_0000);

    function automatic logic [32:0] fin(input logic [QBITS-1:0] q, input logic neg,
                                        input logic ovf);
        logic             big;
        logic [QBITS-1:0] ng;
        big = ovf || (neg ? (q > LIM_NEG) : (q > LIM_POS));
        ng  = '0 - q;
        if (big) begin
            return {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return {1'b0, neg ? ng[31:0] : q[31:0]};
    endfunction

    logic [32:0] n_dre, n_dim;
    logic [31:0] n_re, n_im;
    logic [1:0]  n_st;

    always_comb begin
        n_dre = fin(i_q_re, i_neg_re, i_ovf_re);
        n_dim = fin(i_q_im, i_neg_im, i_ovf_im);
        n_re  = i_side.re;
        n_im  = i_side.im;
        n_st  = i_side.ovf ? ST_OVF : ST_OK;
        if (i_side.is_div) begin
            if (i_side.dz) begin
                n_re = '0;
                n_im = '0;
                n_st = ST_DZ;
            end else begin
                n_re = n_dre[31:0];
                n_im = n_dim[31:0];
                n_st = (n_dre[32] | n_dim[32]) ? ST_OVF : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_res_re   <= n_re;
        o_res_im   <= n_im;
        o_is_equal <= i_side.eq;
        o_status   <= n_st;
    end

endmodule
